### rtl/slt_pkg.sv
// ============================================================================
// slt_pkg
// Shared types and codes of the script lexer token classifier.
// ============================================================================
`default_nettype none

package slt_pkg;

    // Scan modes of the front part.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_OP     = 3'd4;
    localparam logic [2:0] MODE_ERROR  = 3'd5;

    // Token kinds.
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_NUMBER  = 5'd1;
    localparam logic [4:0] KIND_STRING  = 5'd2;
    localparam logic [4:0] KIND_OP      = 5'd3;
    localparam logic [4:0] KIND_ASSIGN  = 5'd4;
    localparam logic [4:0] KIND_COMPARE = 5'd5;
    localparam logic [4:0] KIND_LPAREN  = 5'd6;
    localparam logic [4:0] KIND_RPAREN  = 5'd7;
    localparam logic [4:0] KIND_LBRACE  = 5'd8;
    localparam logic [4:0] KIND_RBRACE  = 5'd9;
    localparam logic [4:0] KIND_LBRACK  = 5'd10;
    localparam logic [4:0] KIND_RBRACK  = 5'd11;
    localparam logic [4:0] KIND_SEMI    = 5'd12;
    localparam logic [4:0] KIND_DOT     = 5'd13;
    localparam logic [4:0] KIND_COMMA   = 5'd14;
    localparam logic [4:0] KIND_COLON   = 5'd15;
    localparam logic [4:0] KIND_EOF     = 5'd16;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;

    // Characters with a special role.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_BAR        = 8'h7C;

    // Most result items one source byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // One result item.
    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] text_byte;
        logic       text_valid;
        logic       token_end;
        logic [1:0] error_code;
    } slt_rec_t;

    // What the front hands to the back for one source byte.
    typedef struct packed {
        logic [1:0]                   count;
        slt_rec_t [MAX_RESULTS-1:0]   recs;
    } slt_cmd_t;

endpackage

`default_nettype wire

### rtl/slt_front.sv
// ============================================================================
// slt_front
// Accepts source bytes, tracks the scan mode and the held lookahead byte,
// and turns each byte into a command of up to three result items.
// ============================================================================
`default_nettype none

module slt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        in_byte,
    input  wire logic              has_byte,
    input  wire logic              end_of_input,
    input  wire logic              q_full,
    output logic                   q_push,
    output slt_pkg::slt_cmd_t      q_cmd
);
    import slt_pkg::*;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       hv_reg;
    logic       hv_next;

    logic                       accept;
    logic [1:0]                 n;
    slt_rec_t [MAX_RESULTS-1:0] recs;
    logic                       do_start;
    logic [5:0]                 pk;
    logic [5:0]                 pu;
    logic                       more;
    logic [4:0]                 kind;

    function automatic slt_rec_t mk_rec(input logic [4:0] k, input logic [7:0] b,
                                        input logic v, input logic e,
                                        input logic [1:0] err);
        slt_rec_t r;
        r.token_kind = k;
        r.text_byte  = b;
        r.text_valid = v;
        r.token_end  = e;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
               (c == CH_EQUAL) || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG) ||
               (c == CH_AMP) || (c == CH_BAR);
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        if (c == CH_EQUAL) begin
            k = KIND_ASSIGN;
        end else if ((c == CH_LT) || (c == CH_GT)) begin
            k = KIND_COMPARE;
        end else begin
            k = KIND_OP;
        end
        return k;
    endfunction

    // Returns {pairs, kind} for a two-character operator.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] r;
        r = '0;
        unique case (a) inside
            "+", "-", "*", "/", "%": begin
                if (b == CH_EQUAL) r = {1'b1, KIND_ASSIGN};
            end
            CH_EQUAL, CH_BANG: begin
                if (b == CH_EQUAL) r = {1'b1, KIND_COMPARE};
            end
            CH_LT, CH_GT: begin
                if (b == a) begin
                    r = {1'b1, KIND_OP};
                end else if (b == CH_EQUAL) begin
                    r = {1'b1, KIND_COMPARE};
                end
            end
            CH_AMP, CH_BAR: begin
                if (b == a) begin
                    r = {1'b1, KIND_OP};
                end else if (b == CH_EQUAL) begin
                    r = {1'b1, KIND_ASSIGN};
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Returns {is_punct, kind}.
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            "(":     r = {1'b1, KIND_LPAREN};
            ")":     r = {1'b1, KIND_RPAREN};
            "{":     r = {1'b1, KIND_LBRACE};
            "}":     r = {1'b1, KIND_RBRACE};
            "[":     r = {1'b1, KIND_LBRACK};
            "]":     r = {1'b1, KIND_RBRACK};
            ";":     r = {1'b1, KIND_SEMI};
            ".":     r = {1'b1, KIND_DOT};
            ",":     r = {1'b1, KIND_COMMA};
            ":":     r = {1'b1, KIND_COLON};
            default: r = '0;
        endcase
        return r;
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        hv_next   = hv_reg;
        recs      = '0;
        n         = '0;
        do_start  = 1'b0;
        pk        = pair_kind(held_reg, in_byte);
        pu        = punct_kind(in_byte);
        more      = 1'b0;
        kind      = KIND_IDENT;

        if (has_byte) begin
            unique case (mode_reg) inside
                MODE_IDENT, MODE_NUMBER: begin
                    kind = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
                    more = (mode_reg == MODE_IDENT) ? is_ident_char(in_byte)
                                                    : is_digit(in_byte);
                    if (more) begin
                        recs[n] = mk_rec(kind, held_reg, 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        held_next = in_byte;
                        hv_next   = 1'b1;
                    end else begin
                        recs[n] = mk_rec(kind, held_reg, 1'b1, 1'b1, ERR_NONE);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_OP: begin
                    if (pk[5]) begin
                        recs[n] = mk_rec(pk[4:0], held_reg, 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        recs[n] = mk_rec(pk[4:0], in_byte, 1'b1, 1'b1, ERR_NONE);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        held_next = '0;
                        hv_next   = 1'b0;
                    end else begin
                        recs[n] = mk_rec(single_kind(held_reg), held_reg, 1'b1, 1'b1,
                                         ERR_NONE);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (in_byte == CH_QUOTE) begin
                        if (hv_reg) begin
                            recs[n] = mk_rec(KIND_STRING, held_reg, 1'b1, 1'b1, ERR_NONE);
                        end else begin
                            recs[n] = mk_rec(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
                        end
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        held_next = '0;
                        hv_next   = 1'b0;
                    end else begin
                        if (hv_reg) begin
                            recs[n] = mk_rec(KIND_STRING, held_reg, 1'b1, 1'b0, ERR_NONE);
                            n = n + 2'd1;
                        end
                        held_next = in_byte;
                        hv_next   = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    do_start = 1'b1;
                end
                default: begin
                    // Error mode drops bytes until end of input.
                end
            endcase
        end

        if (do_start) begin
            held_next = '0;
            hv_next   = 1'b0;
            if (is_digit(in_byte)) begin
                mode_next = MODE_NUMBER;
                held_next = in_byte;
                hv_next   = 1'b1;
            end else if (is_alpha(in_byte) || (in_byte == CH_UNDERSCORE)) begin
                mode_next = MODE_IDENT;
                held_next = in_byte;
                hv_next   = 1'b1;
            end else if (is_space(in_byte)) begin
                mode_next = MODE_IDLE;
            end else if (in_byte == CH_QUOTE) begin
                mode_next = MODE_STRING;
            end else if (is_op_start(in_byte)) begin
                mode_next = MODE_OP;
                held_next = in_byte;
                hv_next   = 1'b1;
            end else if (pu[5]) begin
                mode_next = MODE_IDLE;
                recs[n] = mk_rec(pu[4:0], in_byte, 1'b1, 1'b1, ERR_NONE);
                n = n + 2'd1;
            end else begin
                mode_next = MODE_ERROR;
                recs[n] = mk_rec(KIND_IDENT, in_byte, 1'b1, 1'b1, ERR_UNKNOWN);
                n = n + 2'd1;
            end
        end

        if (end_of_input) begin
            unique case (mode_next)
                MODE_IDENT: begin
                    recs[n] = mk_rec(KIND_IDENT, held_next, 1'b1, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_NUMBER: begin
                    recs[n] = mk_rec(KIND_NUMBER, held_next, 1'b1, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_OP: begin
                    recs[n] = mk_rec(single_kind(held_next), held_next, 1'b1, 1'b1,
                                     ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_STRING: begin
                    // A held content byte of an unterminated string is dropped.
                    recs[n] = mk_rec(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_UNTERM);
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            recs[n] = mk_rec(KIND_EOF, 8'd0, 1'b0, 1'b1, ERR_NONE);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            held_next = '0;
            hv_next   = 1'b0;
        end
    end

    assign q_push     = accept && (n != 2'd0);
    assign q_cmd.count = n;
    assign q_cmd.recs  = recs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            held_reg <= '0;
            hv_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            hv_reg   <= hv_next;
        end
    end

endmodule

`default_nettype wire

### rtl/slt_queue.sv
// ============================================================================
// slt_queue
// Short command queue between the front and the back parts.
// ============================================================================
`default_nettype none

module slt_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire slt_pkg::slt_cmd_t wr_cmd,
    output logic                   q_full,
    input  wire logic              rd_en,
    output logic                   rd_valid,
    output slt_pkg::slt_cmd_t      rd_cmd
);
    import slt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slt_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full   = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/slt_back.sv
// ============================================================================
// slt_back
// Steps through the result items of each queued command and presents them
// one per cycle in an output register, while pop keeps that register draining.
// ============================================================================
`default_nettype none

module slt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire slt_pkg::slt_cmd_t q_cmd,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output slt_pkg::slt_rec_t      out_rec
);
    import slt_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       ov_reg;
    logic       ov_next;
    slt_rec_t   rec_reg;
    logic       load;
    logic       last;

    // The output register takes a new item when it is free or being emptied.
    assign load  = q_valid && (!ov_reg || pop);
    assign last  = (idx_reg == (q_cmd.count - 2'd1));
    assign q_pop = load && last;

    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        if (load) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
            ov_next  = 1'b1;
        end else if (pop) begin
            ov_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            rec_reg <= q_cmd.recs[idx_reg];
        end
    end

    assign empty   = !ov_reg;
    assign out_rec = rec_reg;

endmodule

`default_nettype wire

### rtl/script_lexer_token_classifier.sv
// ============================================================================
// script_lexer_token_classifier
// Streaming tokenizer: source bytes in, tagged token characters out.
// ============================================================================
// The first result of a byte passes through the command queue and then the
// output register. Bytes are taken one per cycle while the command queue has
// room; results leave at one per cycle from the output register while pop is
// held, and the back part hands out all results of a byte before the next's.
// Reset clears the scan mode, the lookahead byte, the queue and the output.
`default_nettype none

module script_lexer_token_classifier #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       has_byte,
    input  wire logic       end_of_input,
    output logic            empty,
    input  wire logic       pop,
    output logic [4:0]      token_kind,
    output logic [7:0]      text_byte,
    output logic            text_valid,
    output logic            token_end,
    output logic [1:0]      error_code
);
    import slt_pkg::*;

    logic     q_full;
    logic     q_push;
    slt_cmd_t q_wr_cmd;
    logic     q_valid;
    slt_cmd_t q_rd_cmd;
    logic     q_pop;
    slt_rec_t out_rec;

    slt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_wr_cmd)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_cmd   (q_wr_cmd),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rd_cmd)
    );

    slt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_rd_cmd),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .out_rec (out_rec)
    );

    assign token_kind = out_rec.token_kind;
    assign text_byte  = out_rec.text_byte;
    assign text_valid = out_rec.text_valid;
    assign token_end  = out_rec.token_end;
    assign error_code = out_rec.error_code;

endmodule

`default_nettype wire

### bench/script_lexer_token_classifier_checker.sv
// ============================================================================
// script_lexer_token_classifier_checker
// Watches both transfer channels of the token classifier. It predicts the
// tagged token characters of every accepted source byte, keeps them in order
// and compares each accepted result with the oldest prediction.
// ============================================================================
`default_nettype none

module script_lexer_token_classifier_checker
    import slt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] in_byte,
    input  wire logic       has_byte,
    input  wire logic       end_of_input,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [4:0] token_kind,
    input  wire logic [7:0] text_byte,
    input  wire logic       text_valid,
    input  wire logic       token_end,
    input  wire logic [1:0] error_code,
    output int              fail_count,
    output int              pending
);

    slt_rec_t   expected_chars[$];

    // Predicted lexer state: scan mode and the one byte of lookahead.
    logic [2:0] scan_mode;
    logic [7:0] look_byte;
    logic       look_valid;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [4:0] single_op_kind(logic [7:0] c);
        if (c == CH_EQUAL)
            return KIND_ASSIGN;
        if (c == CH_LT || c == CH_GT)
            return KIND_COMPARE;
        return KIND_OP;
    endfunction

    // Kind of the two-character operator a b, or -1 when they do not pair.
    function automatic int pair_op_kind(logic [7:0] a, logic [7:0] b);
        case (a)
            "+", "-", "*", "/", "%":
                return (b == CH_EQUAL) ? int'(KIND_ASSIGN) : -1;
            CH_EQUAL, CH_BANG:
                return (b == CH_EQUAL) ? int'(KIND_COMPARE) : -1;
            CH_LT, CH_GT:
            begin
                if (b == a)
                    return int'(KIND_OP);
                return (b == CH_EQUAL) ? int'(KIND_COMPARE) : -1;
            end
            CH_AMP, CH_BAR:
            begin
                if (b == a)
                    return int'(KIND_OP);
                return (b == CH_EQUAL) ? int'(KIND_ASSIGN) : -1;
            end
            default:
                return -1;
        endcase
    endfunction

    function automatic int punct_kind(logic [7:0] c);
        case (c)
            "(":     return int'(KIND_LPAREN);
            ")":     return int'(KIND_RPAREN);
            "{":     return int'(KIND_LBRACE);
            "}":     return int'(KIND_RBRACE);
            "[":     return int'(KIND_LBRACK);
            "]":     return int'(KIND_RBRACK);
            ";":     return int'(KIND_SEMI);
            ".":     return int'(KIND_DOT);
            ",":     return int'(KIND_COMMA);
            ":":     return int'(KIND_COLON);
            default: return -1;
        endcase
    endfunction

    task automatic add_char(logic [4:0] kind, logic [7:0] ch, logic valid,
                            logic last, logic [1:0] err);
        slt_rec_t r;
        r.token_kind = kind;
        r.text_byte  = ch;
        r.text_valid = valid;
        r.token_end  = last;
        r.error_code = err;
        expected_chars.push_back(r);
    endtask

    task automatic hold_byte(logic [7:0] c);
        look_byte  = c;
        look_valid = 1'b1;
    endtask

    // A byte that arrives between tokens opens a new one.
    task automatic open_token(logic [7:0] c);
        int pk;
        look_valid = 1'b0;
        look_byte  = 8'h00;
        pk = punct_kind(c);
        if (is_digit(c))
        begin
            scan_mode = MODE_NUMBER;
            hold_byte(c);
        end
        else if (is_alpha(c) || c == CH_UNDERSCORE)
        begin
            scan_mode = MODE_IDENT;
            hold_byte(c);
        end
        else if (c == " " || (c >= 8'd9 && c <= 8'd13))
            scan_mode = MODE_IDLE;
        else if (c == CH_QUOTE)
            scan_mode = MODE_STRING;
        else if (pair_op_kind(c, CH_EQUAL) >= 0 || c == CH_LT || c == CH_GT)
        begin
            scan_mode = MODE_OP;
            hold_byte(c);
        end
        else if (pk >= 0)
        begin
            scan_mode = MODE_IDLE;
            add_char(pk[4:0], c, 1'b1, 1'b1, ERR_NONE);
        end
        else
        begin
            scan_mode = MODE_ERROR;
            add_char(KIND_IDENT, c, 1'b1, 1'b1, ERR_UNKNOWN);
        end
    endtask

    task automatic clear_scan();
        scan_mode  = MODE_IDLE;
        look_byte  = 8'h00;
        look_valid = 1'b0;
    endtask

    task automatic scan_source_byte(logic [7:0] c, logic has, logic fin);
        logic [4:0] kind;
        bit         more;
        int         pk;
        if (has)
        begin
            case (scan_mode)
                MODE_IDENT, MODE_NUMBER:
                begin
                    kind = (scan_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
                    more = (scan_mode == MODE_IDENT) ?
                           (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) :
                           is_digit(c);
                    if (more)
                    begin
                        add_char(kind, look_byte, 1'b1, 1'b0, ERR_NONE);
                        hold_byte(c);
                    end
                    else
                    begin
                        add_char(kind, look_byte, 1'b1, 1'b1, ERR_NONE);
                        open_token(c);
                    end
                end
                MODE_OP:
                begin
                    pk = pair_op_kind(look_byte, c);
                    if (pk >= 0)
                    begin
                        add_char(pk[4:0], look_byte, 1'b1, 1'b0, ERR_NONE);
                        add_char(pk[4:0], c, 1'b1, 1'b1, ERR_NONE);
                        clear_scan();
                    end
                    else
                    begin
                        add_char(single_op_kind(look_byte), look_byte, 1'b1, 1'b1,
                                 ERR_NONE);
                        open_token(c);
                    end
                end
                MODE_STRING:
                begin
                    // The closing quote is marked on the last content character,
                    // or on an empty character when the string has none.
                    if (c == CH_QUOTE)
                    begin
                        if (look_valid)
                            add_char(KIND_STRING, look_byte, 1'b1, 1'b1, ERR_NONE);
                        else
                            add_char(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
                        clear_scan();
                    end
                    else
                    begin
                        if (look_valid)
                            add_char(KIND_STRING, look_byte, 1'b1, 1'b0, ERR_NONE);
                        hold_byte(c);
                    end
                end
                MODE_IDLE:
                    open_token(c);
                default:
                    ;
            endcase
        end
        if (fin)
        begin
            case (scan_mode)
                MODE_IDENT:
                    add_char(KIND_IDENT, look_byte, 1'b1, 1'b1, ERR_NONE);
                MODE_NUMBER:
                    add_char(KIND_NUMBER, look_byte, 1'b1, 1'b1, ERR_NONE);
                MODE_OP:
                    add_char(single_op_kind(look_byte), look_byte, 1'b1, 1'b1,
                             ERR_NONE);
                MODE_STRING:
                    add_char(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_UNTERM);
                default:
                    ;
            endcase
            add_char(KIND_EOF, 8'h00, 1'b0, 1'b1, ERR_NONE);
            clear_scan();
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        slt_rec_t want;
        if (!rst_n)
        begin
            clear_scan();
            expected_chars.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (push && !full)
                scan_source_byte(in_byte, has_byte, end_of_input);
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("result transfer with nothing expected: kind %0d byte %0d",
                           token_kind, text_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    check_field("token_kind", want.token_kind, token_kind);
                    check_field("text_byte", want.text_byte, text_byte);
                    check_field("text_valid", want.text_valid, text_valid);
                    check_field("token_end", want.token_end, token_end);
                    check_field("error_code", want.error_code, error_code);
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

`default_nettype wire

### bench/script_lexer_token_classifier_tb.sv
// ============================================================================
// script_lexer_token_classifier_tb
// Feeds the token classifier a directed set of source bytes, then random
// token streams with noise, with random gaps on both sides for most of the run. A checker
// beside the block predicts and compares every result.
// ============================================================================
`default_nettype none

module script_lexer_token_classifier_tb;
    import slt_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       push         = 1'b0;
    logic [7:0] in_byte      = 8'h00;
    logic       has_byte     = 1'b0;
    logic       end_of_input = 1'b0;
    logic       pop          = 1'b0;
    logic       full;
    logic       empty;
    logic [4:0] token_kind;
    logic [7:0] text_byte;
    logic       text_valid;
    logic       token_end;
    logic [1:0] error_code;

    int fail_count;
    int pending;
    int sent_count;
    int stall_cycles;
    bit gaps_on = 1'b1;

    string op_list[26] = '{"+", "-", "*", "/", "%", "=", "<", ">", "!", "&", "|",
                           "+=", "-=", "*=", "/=", "%=", "==", "<<", ">>", "<=",
                           ">=", "!=", "&&", "||", "&=", "|="};
    string punct_list = "(){}[];.,:";

    script_lexer_token_classifier uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .end_of_input (end_of_input),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .text_byte    (text_byte),
        .text_valid   (text_valid),
        .token_end    (token_end),
        .error_code   (error_code)
    );

    script_lexer_token_classifier_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .end_of_input (end_of_input),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .text_byte    (text_byte),
        .text_valid   (text_valid),
        .token_end    (token_end),
        .error_code   (error_code),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // Result side: pop drops at random while gaps are enabled.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("script_lexer_token_classifier_tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(logic [7:0] b, logic has, logic fin);
        while (gaps_on && $urandom_range(99) < 11)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        in_byte      <= b;
        has_byte     <= has;
        end_of_input <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        if (has || fin)
            sent_count++;
    endtask

    task automatic send_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, fin_last && i == s.len() - 1);
    endtask

    task automatic wait_results();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] ident_char(bit lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_UNDERSCORE;
        return 8'("0" + r - 53);
    endfunction

    task automatic send_random_token();
        int pick;
        int len;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick < 4)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_item(ident_char(i == 0), 1'b1, 1'b0);
        end
        else if (pick < 6)
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
        end
        else if (pick < 8)
        begin
            // Any byte but the quote may be string content; now and then the
            // closing quote is left out.
            len = $urandom_range(0, 5);
            send_item(CH_QUOTE, 1'b1, 1'b0);
            for (int i = 0; i < len; i++)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE)
                    c = "q";
                send_item(c, 1'b1, 1'b0);
            end
            if ($urandom_range(3) != 0)
                send_item(CH_QUOTE, 1'b1, 1'b0);
        end
        else if (pick < 12)
            send_text(op_list[$urandom_range(0, 25)], 1'b0);
        else if (pick < 14)
            send_item(punct_list[$urandom_range(0, 9)], 1'b1, 1'b0);
        else if (pick < 16)
            send_item(($urandom_range(3) == 0) ? 8'd32 : 8'($urandom_range(9, 13)),
                      1'b1, 1'b0);
        else if (pick == 16)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        else if (pick == 17)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        else
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(1)), 1'b1);
    endtask

    initial
    begin
        bit drained;
        drained = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: identifier extremes and operator pairs, an empty and an
        // unterminated string, an unknown byte with dropped bytes after it,
        // a bare marker, and punctuation closed by end of input.
        send_text("_Zaz09>>=!", 1'b0);
        send_text("\"\"\"", 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_text("{a}", 1'b1);

        sent_count = 0;
        while (sent_count < 150)
        begin
            gaps_on = !(sent_count >= 60 && sent_count < 110);
            if (!drained && sent_count >= 80)
            begin
                wait_results();
                drained = 1'b1;
            end
            send_random_token();
        end
        gaps_on = 1'b1;
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);

        wait_results();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("script_lexer_token_classifier_tb passed");
        else
            $display("script_lexer_token_classifier_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
